>>> hdl/pnf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fbm Perlin noise block.
package pnf_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int COORD_W    = 32;
  localparam int OCT_W      = 5;
  localparam int PERS_W     = 17;
  localparam int AMP_W      = 17;
  localparam int AMP_SUM_W  = 21;
  localparam int OUT_W      = 17;
  localparam int OUT_FRAC   = 15;
  localparam int QUO_W      = 18;
  localparam int MAG_W      = QUO_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int WB_SEL_W   = 3;

  localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;
  localparam logic [OUT_W-1:0] SAT_MAX = 17'h0FFFF;
  localparam logic [OUT_W-1:0] SAT_MIN = 17'h10000;

  localparam logic OPC_EVAL = 1'b0;
  localparam logic OPC_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 2'd1;

  localparam logic [2:0] WB_NONE  = 3'd0;
  localparam logic [2:0] WB_T2    = 3'd1;
  localparam logic [2:0] WB_Q     = 3'd2;
  localparam logic [2:0] WB_T3    = 3'd3;
  localparam logic [2:0] WB_FADE  = 3'd4;
  localparam logic [2:0] WB_LERP  = 3'd5;
  localparam logic [2:0] WB_TOTAL = 3'd6;
  localparam logic [2:0] WB_AMP   = 3'd7;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } perm_wr_t;

  typedef struct packed {
    logic                    done;
    logic signed [OUT_W-1:0] value;
  } div_res_t;

endpackage

>>> hdl/pnf_perm_mem.sv
`timescale 1ns / 1ps
// Permutation table memory with identity readback for entries never written.
module pnf_perm_mem (
  input  logic                    clk,
  input  logic                    rst,
  input  pnf_pkg::perm_wr_t       wr,
  input  logic [pnf_pkg::IDX_W-1:0] rd_addr,
  output logic [pnf_pkg::IDX_W-1:0] rd_data
);
  import pnf_pkg::*;

  logic [IDX_W-1:0]      mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] written;
  logic [IDX_W-1:0]      mem_q;
  logic [IDX_W-1:0]      addr_q;
  logic                  written_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q  <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      written_q <= written[rd_addr];
    end
  end

  assign rd_data = written_q ? mem_q : addr_q;

endmodule

>>> hdl/pnf_divider.sv
`timescale 1ns / 1ps
// Restoring divider that normalizes the weighted sum and saturates to Q2.15.
module pnf_divider #(
  parameter int DIV_W = 55
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              neg,
  input  logic [DIV_W-1:0]  num,
  input  logic [DIV_W-1:0]  den,
  output pnf_pkg::div_res_t res
);
  import pnf_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_FIN  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic             neg_q;
  logic [MAG_W-1:0] mag;
  logic [OUT_W-1:0] pos_val;
  logic [OUT_W-1:0] neg_val;

  always_comb begin
    mag     = MAG_W'(quo) + MAG_W'(neg_q && (rem != '0));
    pos_val = (mag > MAG_W'(SAT_MAX)) ? SAT_MAX : OUT_W'(mag);
    neg_val = (mag > MAG_W'(SAT_MIN)) ? SAT_MIN : OUT_W'(0) - OUT_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DV_IDLE;
      res.done <= 1'b0;
    end else if (start) begin
      state    <= DV_RUN;
      res.done <= 1'b0;
      rem      <= num;
      dsh      <= den << (QUO_W - 1);
      quo      <= '0;
      cnt      <= CNT_W'(QUO_W - 1);
      neg_q    <= neg;
    end else begin
      unique case (state)
        DV_RUN: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (cnt == '0) begin
            state <= DV_FIN;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        DV_FIN: begin
          res.value <= neg_q ? neg_val : pos_val;
          res.done  <= 1'b1;
          state     <= DV_IDLE;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/perlin_noise_fbm_3d.sv
`timescale 1ns / 1ps
// Top level: octave sequencer, shared multiplier datapath, table and divider.
//
//   Channel  Direction  Handshake             Payload
//   in       receive    in_valid / in_stall   opcode, coord_x/y/z, table_index, table_value
//   out      send       out_valid / out_stall noise_value
//   cfg      receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
// An evaluate item runs a per-octave schedule set by the single shared
// multiplier and the table read port, then the 18-step divider and the result
// transfer. A load item writes its table entry while the block stays idle.
// Reset clears control state and the written-entry flags, so the table reads
// as identity at once; there is no clearing pass. A waiting result does not
// block the next transfer on the input channel.
module perlin_noise_fbm_3d #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic signed [pnf_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pnf_pkg::COORD_W-1:0] coord_y,
  input  logic signed [pnf_pkg::COORD_W-1:0] coord_z,
  input  logic [pnf_pkg::IDX_W-1:0]          table_index,
  input  logic [pnf_pkg::IDX_W-1:0]          table_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pnf_pkg::OUT_W-1:0]   noise_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pnf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pnf_pkg::PERS_W-1:0]         cfg_data
);
  import pnf_pkg::*;

  localparam int NW     = FRAC_BITS + 3;
  localparam int MW     = (FRAC_BITS + 5 > 18) ? FRAC_BITS + 5 : 18;
  localparam int PW     = 2 * MW;
  localparam int TOT_W  = FRAC_BITS + 24;
  localparam int DIV_W  = FRAC_BITS + 39;
  localparam int FADE_W = FRAC_BITS + 1;
  localparam int QV_W   = FRAC_BITS + 4;

  localparam logic signed [NW-1:0] ONE_N = NW'(1) << FRAC_BITS;
  localparam logic signed [MW-1:0] K15   = MW'(15) << FRAC_BITS;
  localparam logic signed [MW-1:0] K10   = MW'(10) << FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [4:0] STEP_LAST = 5'd23;

  logic [1:0]            state;
  logic [4:0]            step;
  logic [OCT_W-1:0]      oct;
  logic [OCT_W-1:0]      oct_last;
  logic [OCT_W-1:0]      octave_count;
  logic [PERS_W-1:0]     persistence;
  logic [OCT_W-1:0]      oct_lim;
  logic [PERS_W-1:0]     pers_lim;
  logic [PERS_W-1:0]     pers_q;
  logic [COORD_W-1:0]    cx, cy, cz;
  logic [AMP_W-1:0]      amp;
  logic [AMP_SUM_W-1:0]  amp_sum;
  logic signed [TOT_W-1:0] total;
  logic [TOT_W-1:0]      tot_mag;

  logic [IDX_W-1:0]      xi, yi, zi;
  logic [FRAC_BITS-1:0]  frac [3];
  logic [IDX_W-1:0]      a_r, b_r, aa, ab, ba, bb;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      rd_data;
  perm_wr_t              perm_wr;

  logic signed [NW-1:0]  g [8];
  logic signed [NW-1:0]  lr [7];
  logic [FRAC_BITS-1:0]  t2 [3];
  logic [FRAC_BITS-1:0]  t3 [3];
  logic [QV_W-1:0]       qv [3];
  logic [FADE_W-1:0]     fade [3];

  logic signed [MW-1:0]  fr_m [3];
  logic signed [MW-1:0]  q_op [3];
  logic signed [MW-1:0]  inner_m [3];
  logic [1:0]            ax_pair, ax_t3, ax_fd;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic [2:0]            iss_kind;
  logic [WB_SEL_W-1:0]   iss_sel;
  logic signed [NW-1:0]  iss_base;
  logic signed [PW-1:0]  p;
  logic signed [PW-1:0]  ps;
  logic [2:0]            wb_kind;
  logic [WB_SEL_W-1:0]   wb_sel;
  logic signed [NW-1:0]  base_q;

  logic [2:0]            gi;
  logic [3:0]            hsh;
  logic signed [NW-1:0]  gx, gy, gz, gu, gv, grad_val;

  logic                  in_take;
  logic                  out_load;
  logic                  div_start;
  logic [DIV_W-1:0]      div_num, div_den;
  div_res_t              div_res;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == ST_DIV) && div_res.done && (!out_valid || !out_stall);

  assign perm_wr.en   = in_take && (opcode == OPC_LOAD);
  assign perm_wr.addr = table_index;
  assign perm_wr.data = table_value;

  always_comb begin
    oct_lim = octave_count;
    if (octave_count == '0) begin
      oct_lim = OCT_W'(1);
    end else if (octave_count > OCT_W'(MAX_OCTAVES)) begin
      oct_lim = OCT_W'(MAX_OCTAVES);
    end
    pers_lim = (persistence > AMP_ONE) ? AMP_ONE : persistence;
  end

  assign xi = cx[FRAC_BITS +: IDX_W];
  assign yi = cy[FRAC_BITS +: IDX_W];
  assign zi = cz[FRAC_BITS +: IDX_W];
  assign frac[0] = cx[FRAC_BITS-1:0];
  assign frac[1] = cy[FRAC_BITS-1:0];
  assign frac[2] = cz[FRAC_BITS-1:0];

  always_comb begin
    unique case (step)
      5'd0:    rd_addr = xi;
      5'd1:    rd_addr = xi + IDX_W'(1);
      5'd2:    rd_addr = a_r;
      5'd3:    rd_addr = a_r + IDX_W'(1);
      5'd4:    rd_addr = b_r;
      5'd5:    rd_addr = b_r + IDX_W'(1);
      5'd6:    rd_addr = aa;
      5'd7:    rd_addr = ba;
      5'd8:    rd_addr = ab;
      5'd9:    rd_addr = bb;
      5'd10:   rd_addr = aa + IDX_W'(1);
      5'd11:   rd_addr = ba + IDX_W'(1);
      5'd12:   rd_addr = ab + IDX_W'(1);
      5'd13:   rd_addr = bb + IDX_W'(1);
      default: rd_addr = xi;
    endcase
  end

  always_comb begin
    gi  = 3'(step - 5'd7);
    hsh = rd_data[3:0];
    gx  = NW'(frac[0]) - (gi[0] ? ONE_N : NW'(0));
    gy  = NW'(frac[1]) - (gi[1] ? ONE_N : NW'(0));
    gz  = NW'(frac[2]) - (gi[2] ? ONE_N : NW'(0));
    gu  = (hsh < 4'd8) ? gx : gy;
    if (hsh < 4'd4) begin
      gv = gy;
    end else if (hsh == 4'd12 || hsh == 4'd14) begin
      gv = gx;
    end else begin
      gv = gz;
    end
    grad_val = (hsh[0] ? -gu : gu) + (hsh[1] ? -gv : gv);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fr_m[i]    = MW'(frac[i]);
      q_op[i]    = K15 - MW'(6) * fr_m[i];
      inner_m[i] = K10 - MW'(qv[i]);
    end
    ax_pair  = step[2:1];
    ax_t3    = 2'(step - 5'd6);
    ax_fd    = 2'(step - 5'd9);
    mul_a    = '0;
    mul_b    = '0;
    iss_kind = WB_NONE;
    iss_sel  = '0;
    iss_base = '0;
    case (step) inside
      5'd0, 5'd2, 5'd4: begin
        mul_a    = fr_m[ax_pair];
        mul_b    = fr_m[ax_pair];
        iss_kind = WB_T2;
        iss_sel  = WB_SEL_W'(ax_pair);
      end
      5'd1, 5'd3, 5'd5: begin
        mul_a    = fr_m[ax_pair];
        mul_b    = q_op[ax_pair];
        iss_kind = WB_Q;
        iss_sel  = WB_SEL_W'(ax_pair);
      end
      5'd6, 5'd7, 5'd8: begin
        mul_a    = MW'(t2[ax_t3]);
        mul_b    = fr_m[ax_t3];
        iss_kind = WB_T3;
        iss_sel  = WB_SEL_W'(ax_t3);
      end
      5'd9, 5'd10, 5'd11: begin
        mul_a    = MW'(t3[ax_fd]);
        mul_b    = inner_m[ax_fd];
        iss_kind = WB_FADE;
        iss_sel  = WB_SEL_W'(ax_fd);
      end
      5'd12: begin
        mul_a    = MW'(fade[0]);
        mul_b    = MW'(g[1]) - MW'(g[0]);
        iss_base = g[0];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(0);
      end
      5'd13: begin
        mul_a    = MW'(fade[0]);
        mul_b    = MW'(g[3]) - MW'(g[2]);
        iss_base = g[2];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(1);
      end
      5'd14: begin
        mul_a    = MW'(fade[0]);
        mul_b    = MW'(g[5]) - MW'(g[4]);
        iss_base = g[4];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(2);
      end
      5'd15: begin
        mul_a    = MW'(fade[0]);
        mul_b    = MW'(g[7]) - MW'(g[6]);
        iss_base = g[6];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(3);
      end
      5'd16: begin
        mul_a    = MW'(fade[1]);
        mul_b    = MW'(lr[1]) - MW'(lr[0]);
        iss_base = lr[0];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(4);
      end
      5'd17: begin
        mul_a    = MW'(fade[1]);
        mul_b    = MW'(lr[3]) - MW'(lr[2]);
        iss_base = lr[2];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(5);
      end
      5'd19: begin
        mul_a    = MW'(fade[2]);
        mul_b    = MW'(lr[5]) - MW'(lr[4]);
        iss_base = lr[4];
        iss_kind = WB_LERP;
        iss_sel  = WB_SEL_W'(6);
      end
      5'd21: begin
        mul_a    = MW'(lr[6]);
        mul_b    = MW'(amp);
        iss_kind = WB_TOTAL;
      end
      5'd22: begin
        mul_a    = MW'(amp);
        mul_b    = MW'(pers_q);
        iss_kind = WB_AMP;
      end
      default: ;
    endcase
  end

  assign ps = p >>> FRAC_BITS;

  assign tot_mag   = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
  assign div_num   = {tot_mag, {OUT_FRAC{1'b0}}};
  assign div_den   = DIV_W'(amp_sum) << FRAC_BITS;
  assign div_start = (state == ST_RUN) && (step == STEP_LAST) && (oct == oct_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wb_kind      <= WB_NONE;
      out_valid    <= 1'b0;
      octave_count <= OCT_W'(1);
      persistence  <= PERS_W'(32768);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_OCTAVES: octave_count <= cfg_data[OCT_W-1:0];
          CFG_PERSIST: persistence  <= cfg_data;
          default: ;
        endcase
      end

      wb_kind <= (state == ST_RUN) ? iss_kind : WB_NONE;
      wb_sel  <= iss_sel;
      base_q  <= iss_base;
      p       <= mul_a * mul_b;

      case (wb_kind)
        WB_T2:    t2[wb_sel[1:0]]   <= ps[FRAC_BITS-1:0];
        WB_Q:     qv[wb_sel[1:0]]   <= ps[QV_W-1:0];
        WB_T3:    t3[wb_sel[1:0]]   <= ps[FRAC_BITS-1:0];
        WB_FADE:  fade[wb_sel[1:0]] <= ps[FADE_W-1:0];
        WB_LERP:  lr[wb_sel]        <= base_q + ps[NW-1:0];
        WB_TOTAL: begin
          total   <= total + TOT_W'(p);
          amp_sum <= amp_sum + AMP_SUM_W'(amp);
        end
        WB_AMP:   amp <= p[16 +: AMP_W];
        default: ;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_take && opcode == OPC_EVAL) begin
            cx       <= coord_x;
            cy       <= coord_y;
            cz       <= coord_z;
            oct      <= '0;
            oct_last <= oct_lim - OCT_W'(1);
            pers_q   <= pers_lim;
            amp      <= AMP_ONE;
            amp_sum  <= '0;
            total    <= '0;
            step     <= '0;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          case (step)
            5'd1:    a_r <= rd_data + yi;
            5'd2:    b_r <= rd_data + yi;
            5'd3:    aa  <= rd_data + zi;
            5'd4:    ab  <= rd_data + zi;
            5'd5:    ba  <= rd_data + zi;
            5'd6:    bb  <= rd_data + zi;
            default: ;
          endcase
          if (step >= 5'd7 && step <= 5'd14) begin
            g[gi] <= grad_val;
          end
          if (step == STEP_LAST) begin
            step <= '0;
            if (oct == oct_last) begin
              state <= ST_DIV;
            end else begin
              oct <= oct + OCT_W'(1);
              cx  <= {cx[COORD_W-2:0], 1'b0};
              cy  <= {cy[COORD_W-2:0], 1'b0};
              cz  <= {cz[COORD_W-2:0], 1'b0};
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_DIV: begin
          if (out_load) begin
            noise_value <= div_res.value;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  pnf_perm_mem u_perm (
    .clk     (clk),
    .rst     (rst),
    .wr      (perm_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pnf_divider #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (total[TOT_W-1]),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

endmodule

>>> hdl/pnf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the fbm Perlin noise block and its bind statement.
module pnf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               opcode,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [pnf_pkg::OUT_W-1:0]   noise_value,
  input logic                               cfg_ready
);
  import pnf_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value))
    else $error("Stalled result changed or vanished.");

  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("Block not idle after reset.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OPC_LOAD && !out_valid |=> !out_valid)
    else $error("A table load produced a result.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OPC_EVAL |=> in_stall && !cfg_ready)
    else $error("Block not busy after an evaluate transfer.");

endmodule

bind perlin_noise_fbm_3d pnf_checker u_pnf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .opcode      (opcode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .noise_value (noise_value),
  .cfg_ready   (cfg_ready)
);

>>> dv/perlin_noise_fbm_3d_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fbm Perlin noise block: directed table, then random phases.
module perlin_noise_fbm_3d_tb;
  import pnf_pkg::*;

  localparam int  FRAC        = 16;
  localparam int  OCT_MAX     = 16;
  localparam int  DRAIN_WAIT  = 24 * OCT_MAX + 60;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  HOLD_LEN    = 1500;

  localparam logic [1:0] CFG_BAD_LO = 2'd2;
  localparam logic [1:0] CFG_BAD_HI = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [31:0]       x, y, z;
    logic [7:0]        ti, tv;
    logic [1:0]        cidx;
    logic [16:0]       cdat;
    bit                known;
    logic signed [16:0] kval;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OPC_EVAL;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [7:0] table_index = '0, table_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] noise_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  perlin_noise_fbm_3d DUT (.*);

  logic [7:0]  perm_mirror [256];
  logic [4:0]  octs_reg;
  logic [16:0] pers_reg;
  logic signed [16:0] noise_q [$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("perlin_noise_fbm_3d_tb NOT OK");
      $finish;
    end
  end

  function automatic longint fade_of(longint t);
    longint t2, t3, q;
    t2 = (t * t) >>> FRAC;
    t3 = (t2 * t) >>> FRAC;
    q = (t * (15 * 65536 - 6 * t)) >>> FRAC;
    return (t3 * (10 * 65536 - q)) >>> FRAC;
  endfunction

  function automatic longint mix(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> FRAC);
  endfunction

  function automatic longint grad(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint lattice_noise(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
    longint x, y, z, u, v, w, x1, y1, z1, n0, n1;
    xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
    x = cx[15:0]; y = cy[15:0]; z = cz[15:0];
    u = fade_of(x); v = fade_of(y); w = fade_of(z);
    a  = perm_mirror[xi] + yi;
    aa = perm_mirror[a] + zi;
    ab = perm_mirror[8'(a + 1)] + zi;
    b  = perm_mirror[8'(xi + 1)] + yi;
    ba = perm_mirror[b] + zi;
    bb = perm_mirror[8'(b + 1)] + zi;
    x1 = x - 65536; y1 = y - 65536; z1 = z - 65536;
    n0 = mix(v, mix(u, grad(perm_mirror[aa], x, y, z), grad(perm_mirror[ba], x1, y, z)),
                mix(u, grad(perm_mirror[ab], x, y1, z), grad(perm_mirror[bb], x1, y1, z)));
    n1 = mix(v, mix(u, grad(perm_mirror[8'(aa + 1)], x, y, z1),
                       grad(perm_mirror[8'(ba + 1)], x1, y, z1)),
                mix(u, grad(perm_mirror[8'(ab + 1)], x, y1, z1),
                       grad(perm_mirror[8'(bb + 1)], x1, y1, z1)));
    return mix(w, n0, n1);
  endfunction

  function automatic logic signed [16:0] fbm_noise(logic [31:0] cx, logic [31:0] cy,
                                                   logic [31:0] cz);
    int octs;
    longint pers, amp, total, amp_sum, num, den, q;
    octs = octs_reg;
    if (octs < 1) octs = 1;
    if (octs > OCT_MAX) octs = OCT_MAX;
    pers = (pers_reg > 65536) ? 65536 : pers_reg;
    amp = 65536; total = 0; amp_sum = 0;
    for (int i = 0; i < octs; i++) begin
      total += lattice_noise(cx << i, cy << i, cz << i) * amp;
      amp_sum += amp;
      amp = (amp * pers) >> 16;
    end
    num = total * 32768;
    den = amp_sum * 65536;
    q = (num >= 0) ? num / den : -(((-num) + den - 1) / den);
    if (q > 65535) q = 65535;
    if (q < -65536) q = -65536;
    return 17'(q);
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < 29);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        $error("unexpected noise_value transfer: actual %0d", noise_value);
        errors++;
      end else begin
        if (noise_value !== noise_q[0]) begin
          $error("noise_value mismatch: expected %0d actual %0d", noise_q[0], noise_value);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  task automatic offer_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [7:0] ti, logic [7:0] tv, bit known,
                            logic signed [16:0] kval);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op; coord_x = x; coord_y = y; coord_z = z;
    table_index = ti; table_value = tv;
    do @(posedge clk); while (in_stall);
    if (op == OPC_LOAD) perm_mirror[ti] = tv;
    else noise_q.push_back(known ? kval : fbm_noise(x, y, z));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (noise_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_OCTAVES) octs_reg = data[4:0];
    else if (idx == CFG_PERSIST) pers_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(3))
      0: c = 32'($signed(c[19:0]));
      1: c = 32'($signed(c[23:0]));
      default: ;
    endcase
    return c;
  endfunction

  task automatic random_phase(int n, int max_oct);
    logic [16:0] p;
    settle();
    write_reg(CFG_OCTAVES, 17'($urandom_range(max_oct, 1)));
    case ($urandom_range(4))
      0: p = 17'd0;
      1: p = 17'd65536;
      2: p = 17'($urandom_range(131071, 65537));
      default: p = 17'($urandom_range(65535));
    endcase
    write_reg(CFG_PERSIST, p);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        offer_item(OPC_LOAD, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                   1'b0, '0);
      else
        offer_item(OPC_EVAL, rand_coord(), rand_coord(), rand_coord(),
                   8'($urandom), 8'($urandom), 1'b0, '0);
    end
  endtask

  stim_row_t rows [$];

  function automatic stim_row_t item_row(logic op, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [7:0] ti, logic [7:0] tv,
                                         bit known, logic signed [16:0] kval);
    stim_row_t r;
    r = '{kind: ROW_ITEM, op: op, x: x, y: y, z: z, ti: ti, tv: tv,
          cidx: '0, cdat: '0, known: known, kval: kval};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [16:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, op: OPC_EVAL, x: '0, y: '0, z: '0, ti: '0, tv: '0,
          cidx: idx, cdat: data, known: 1'b0, kval: '0};
    return r;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) perm_mirror[i] = 8'(i);
    octs_reg = 5'd1;
    pers_reg = 17'd32768;

    rows.push_back(item_row(OPC_EVAL, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 1'b1, 17'sd0));
    rows.push_back(item_row(OPC_EVAL, 32'h7FFF0000, 32'h80000000, 32'h00050000, 8'd0, 8'd0,
                            1'b1, 17'sd0));
    rows.push_back(item_row(OPC_EVAL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(item_row(OPC_EVAL, 32'h80000000, 32'h80000001, 32'hFFFFFFFF, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(item_row(OPC_EVAL, 32'h00008000, 32'h00008000, 32'h00008000, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(item_row(OPC_EVAL, 32'h0000FFFF, 32'h00000001, 32'hFFFF8000, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(item_row(OPC_LOAD, 32'd0, 32'd0, 32'd0, 8'd0, 8'd255, 1'b0, '0));
    rows.push_back(item_row(OPC_LOAD, 32'd0, 32'd0, 32'd0, 8'd255, 8'd0, 1'b0, '0));
    rows.push_back(item_row(OPC_LOAD, 32'd0, 32'd0, 32'd0, 8'd1, 8'd170, 1'b0, '0));
    rows.push_back(item_row(OPC_EVAL, 32'h00004000, 32'h0000C000, 32'h00002000, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(item_row(OPC_EVAL, 32'h00FF8000, 32'h00FF4000, 32'h00FFC000, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(cfg_row(CFG_OCTAVES, 17'd0));
    rows.push_back(item_row(OPC_EVAL, 32'h00012345, 32'hFFFE6789, 32'h0003ABCD, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(cfg_row(CFG_OCTAVES, 17'd31));
    rows.push_back(cfg_row(CFG_PERSIST, 17'h1FFFF));
    rows.push_back(item_row(OPC_EVAL, 32'h00012345, 32'hFFFE6789, 32'h0003ABCD, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(item_row(OPC_EVAL, 32'h00030000, 32'hFFFD0000, 32'h00000000, 8'd0, 8'd0,
                            1'b1, 17'sd0));
    rows.push_back(cfg_row(CFG_PERSIST, 17'd0));
    rows.push_back(cfg_row(CFG_BAD_LO, 17'h1FFFF));
    rows.push_back(cfg_row(CFG_BAD_HI, 17'd5));
    rows.push_back(cfg_row(CFG_OCTAVES, 17'd16));
    rows.push_back(item_row(OPC_EVAL, 32'h0000A5A5, 32'h00005A5A, 32'h0000F00F, 8'd0, 8'd0,
                            1'b0, '0));
    rows.push_back(cfg_row(CFG_OCTAVES, 17'd1));
    rows.push_back(cfg_row(CFG_PERSIST, 17'd65536));
    rows.push_back(item_row(OPC_EVAL, 32'h00017FFF, 32'h00028001, 32'h0004FFFF, 8'd0, 8'd0,
                            1'b0, '0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].cidx, rows[i].cdat);
      end else begin
        offer_item(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].ti, rows[i].tv,
                   rows[i].known, rows[i].kval);
      end
    end

    random_phase(150, 4);
    settle();
    hold_req = 1'b1;
    random_phase(120, 2);
    calm = 1'b1;
    random_phase(120, 3);
    calm = 1'b0;
    random_phase(40, 16);
    random_phase(150, 1);
    random_phase(150, 5);
    random_phase(200, 2);
    settle();

    if (errors == 0) begin
      $display("perlin_noise_fbm_3d_tb OK");
    end else begin
      $display("perlin_noise_fbm_3d_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> perlin_noise_fbm_3d.f
hdl/pnf_pkg.sv
hdl/pnf_perm_mem.sv
hdl/pnf_divider.sv
hdl/perlin_noise_fbm_3d.sv
hdl/pnf_checker.sv
dv/perlin_noise_fbm_3d_tb.sv
